// ===== rtl/core/ffra_pkg.sv =====
// Shared constants, codes and types of the first-fit free range allocator.
package ffra_pkg;

    localparam int MAX_HOLES = 64;
    localparam int ADDR_BITS = 48;
    localparam int IDX_BITS  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

    localparam logic [1:0] MODE_FIND    = 2'd0;
    localparam logic [1:0] MODE_CONSUME = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_RANGE_MIN = 1'b0;
    localparam logic CFG_RANGE_MAX = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ADDR_BITS-1:0] range_start;
        logic [ADDR_BITS-1:0] range_end;
        logic [ADDR_BITS-1:0] want_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] found_addr;
    } t_out_item;

    // record handed from cell to cell during a scan
    typedef struct packed {
        logic                 valid;
        t_in_item             req;
        logic                 found;
        logic [ADDR_BITS-1:0] best;
        logic                 hit_v;
        logic [IDX_BITS-1:0]  hit_idx;
        logic [ADDR_BITS-1:0] hit_lo;
        logic [ADDR_BITS-1:0] hit_hi;
        logic                 left_v;
        logic [IDX_BITS-1:0]  left_idx;
        logic [ADDR_BITS-1:0] left_lo;
        logic                 right_v;
        logic [IDX_BITS-1:0]  right_idx;
        logic [ADDR_BITS-1:0] right_hi;
        logic                 free_v;
        logic [IDX_BITS-1:0]  free_idx;
    } t_scan;

    // entry write broadcast to all cells
    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  idx;
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
        logic                 used;
    } t_wr;

    typedef struct packed {
        logic                 en;
        logic                 used;
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
    } t_init;

endpackage

// ===== rtl/core/ffra_cell.sv =====
// One hole entry of the table plus its stage of the scan chain.
module ffra_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ffra_pkg::IDX_BITS-1:0] i_idx,
    input  ffra_pkg::t_init               i_init,
    input  ffra_pkg::t_wr                 i_wr_a,
    input  ffra_pkg::t_wr                 i_wr_b,
    input  ffra_pkg::t_scan               i_rec,
    output ffra_pkg::t_scan               o_rec
);

    logic [ffra_pkg::ADDR_BITS-1:0] r_lo, r_hi;
    logic                           r_used;
    ffra_pkg::t_scan                r_rec, n_rec;
    logic [ffra_pkg::ADDR_BITS-1:0] w_len;

    assign w_len = r_hi - r_lo;

    always_comb begin
        n_rec = i_rec;
        if (r_used && w_len >= i_rec.req.want_length &&
            (!i_rec.found || r_lo < i_rec.best)) begin
            n_rec.found = 1'b1;
            n_rec.best  = r_lo;
        end
        if (!i_rec.hit_v && r_used && r_lo <= i_rec.req.range_start &&
            i_rec.req.range_end <= r_hi) begin
            n_rec.hit_v   = 1'b1;
            n_rec.hit_idx = i_idx;
            n_rec.hit_lo  = r_lo;
            n_rec.hit_hi  = r_hi;
        end
        if (!i_rec.left_v && r_used && r_hi == i_rec.req.range_start) begin
            n_rec.left_v   = 1'b1;
            n_rec.left_idx = i_idx;
            n_rec.left_lo  = r_lo;
        end
        if (!i_rec.right_v && r_used && r_lo == i_rec.req.range_end) begin
            n_rec.right_v   = 1'b1;
            n_rec.right_idx = i_idx;
            n_rec.right_hi  = r_hi;
        end
        if (!i_rec.free_v && !r_used) begin
            n_rec.free_v   = 1'b1;
            n_rec.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid <= 1'b0;
        end else begin
            r_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_init.en) begin
            r_used <= (i_idx == '0) && i_init.used;
            r_lo   <= i_init.lo;
            r_hi   <= i_init.hi;
        end else if (i_wr_a.en && i_wr_a.idx == i_idx) begin
            r_used <= i_wr_a.used;
            r_lo   <= i_wr_a.lo;
            r_hi   <= i_wr_a.hi;
        end else if (i_wr_b.en && i_wr_b.idx == i_idx) begin
            r_used <= i_wr_b.used;
            r_lo   <= i_wr_b.lo;
            r_hi   <= i_wr_b.hi;
        end
    end

    assign o_rec = r_rec;

endmodule

// ===== rtl/core/first_fit_free_range_allocator.sv =====
// Top level: scan chain of hole cells and the operation controller.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//   cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// The request record walks the chain, registered in each cell, then the table is
// updated and the result loaded in S_DONE once the output register is free.
// After reset, and after any register write, the table is rebuilt from the range registers.
// A result held by i_out_stall holds the update; no new item is taken meanwhile.
module first_fit_free_range_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ffra_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ffra_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [ffra_pkg::ADDR_BITS-1:0] i_cfg_data
);

    ffra_pkg::t_state               r_state, n_state;
    logic                           r_init;
    logic [ffra_pkg::ADDR_BITS-1:0] r_range_min, r_range_max;
    ffra_pkg::t_scan                r_rec;
    ffra_pkg::t_out_item            r_out, n_out;
    logic                           r_out_valid;
    ffra_pkg::t_scan                w_chain [ffra_pkg::MAX_HOLES+1];
    ffra_pkg::t_wr                  w_wr_a, w_wr_b;
    ffra_pkg::t_init                w_init;
    logic                           w_accept, w_finish, w_kl, w_kr;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_finish = (r_state == ffra_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].valid = w_accept;
        w_chain[0].req   = i_in_item;
    end

    assign w_init.en   = r_init;
    assign w_init.used = r_range_min < r_range_max;
    assign w_init.lo   = r_range_min;
    assign w_init.hi   = r_range_max;

    for (genvar g = 0; g < ffra_pkg::MAX_HOLES; g++) begin : g_cell
        ffra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ffra_pkg::IDX_BITS'(g)),
            .i_init  (w_init),
            .i_wr_a  (w_wr_a),
            .i_wr_b  (w_wr_b),
            .i_rec   (w_chain[g]),
            .o_rec   (w_chain[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffra_pkg::S_IDLE: if (w_accept) n_state = ffra_pkg::S_SCAN;
            ffra_pkg::S_SCAN: if (w_chain[ffra_pkg::MAX_HOLES].valid) n_state = ffra_pkg::S_DONE;
            ffra_pkg::S_DONE: if (w_finish) n_state = ffra_pkg::S_IDLE;
            default:          n_state = ffra_pkg::S_IDLE;
        endcase
    end

    // outputs: handshake, table update and result
    assign w_kl = r_rec.req.range_start > r_rec.hit_lo;
    assign w_kr = r_rec.hit_hi > r_rec.req.range_end;

    always_comb begin
        o_in_stall = !((r_state == ffra_pkg::S_IDLE) && !r_init);
        n_out      = '{status: ffra_pkg::ST_NOFIT, found_addr: '0};
        w_wr_a     = '0;
        w_wr_b     = '0;
        unique case (r_rec.req.mode)
            ffra_pkg::MODE_FIND: begin
                if (r_rec.found) begin
                    n_out.status     = ffra_pkg::ST_OK;
                    n_out.found_addr = r_rec.best;
                end
            end
            ffra_pkg::MODE_CONSUME: begin
                if (r_rec.req.range_start < r_rec.req.range_end && r_rec.hit_v) begin
                    n_out.status = ffra_pkg::ST_OK;
                    w_wr_a.idx   = r_rec.hit_idx;
                    w_wr_a.lo    = r_rec.hit_lo;
                    w_wr_a.hi    = r_rec.hit_hi;
                    w_wr_a.used  = 1'b1;
                    w_wr_a.en    = 1'b1;
                    if (!w_kl && !w_kr) begin
                        w_wr_a.used = 1'b0;
                        w_wr_a.lo   = '0;
                        w_wr_a.hi   = '0;
                    end else if (w_kl && !w_kr) begin
                        w_wr_a.hi = r_rec.req.range_start;
                    end else if (!w_kl && w_kr) begin
                        w_wr_a.lo = r_rec.req.range_end;
                    end else if (r_rec.free_v) begin
                        w_wr_a.hi   = r_rec.req.range_start;
                        w_wr_b.en   = 1'b1;
                        w_wr_b.idx  = r_rec.free_idx;
                        w_wr_b.lo   = r_rec.req.range_end;
                        w_wr_b.hi   = r_rec.hit_hi;
                        w_wr_b.used = 1'b1;
                    end else begin
                        w_wr_a.en    = 1'b0;
                        n_out.status = ffra_pkg::ST_FULL;
                    end
                end
            end
            ffra_pkg::MODE_RELEASE: begin
                if (r_rec.req.range_start < r_rec.req.range_end) begin
                    n_out.status = ffra_pkg::ST_OK;
                    w_wr_a.en    = 1'b1;
                    w_wr_a.used  = 1'b1;
                    if (r_rec.left_v && r_rec.right_v && r_rec.left_idx != r_rec.right_idx) begin
                        w_wr_a.idx = r_rec.left_idx;
                        w_wr_a.lo  = r_rec.left_lo;
                        w_wr_a.hi  = r_rec.right_hi;
                        w_wr_b.en  = 1'b1;
                        w_wr_b.idx = r_rec.right_idx;
                    end else if (r_rec.left_v) begin
                        w_wr_a.idx = r_rec.left_idx;
                        w_wr_a.lo  = r_rec.left_lo;
                        w_wr_a.hi  = r_rec.req.range_end;
                    end else if (r_rec.right_v) begin
                        w_wr_a.idx = r_rec.right_idx;
                        w_wr_a.lo  = r_rec.req.range_start;
                        w_wr_a.hi  = r_rec.right_hi;
                    end else if (r_rec.free_v) begin
                        w_wr_a.idx = r_rec.free_idx;
                        w_wr_a.lo  = r_rec.req.range_start;
                        w_wr_a.hi  = r_rec.req.range_end;
                    end else begin
                        w_wr_a.en    = 1'b0;
                        n_out.status = ffra_pkg::ST_FULL;
                    end
                end
            end
            default: ;
        endcase
        if (!w_finish) begin
            w_wr_a.en = 1'b0;
            w_wr_b.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffra_pkg::S_IDLE;
            r_init      <= 1'b1;
            r_range_min <= '0;
            r_range_max <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= i_cfg_we;
            if (i_cfg_we) begin
                if (i_cfg_idx == ffra_pkg::CFG_RANGE_MIN) r_range_min <= i_cfg_data;
                if (i_cfg_idx == ffra_pkg::CFG_RANGE_MAX) r_range_max <= i_cfg_data;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ffra_pkg::S_SCAN && w_chain[ffra_pkg::MAX_HOLES].valid) begin
            r_rec <= w_chain[ffra_pkg::MAX_HOLES];
        end
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== dv/ffra_checker.sv =====
// Checker for the free range allocator: predicts each result and compares it.
module ffra_checker
    import ffra_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [ADDR_BITS-1:0] t_addr;

    t_addr     space_lo, space_hi;
    t_addr     hole_lo [MAX_HOLES];
    t_addr     hole_hi [MAX_HOLES];
    logic      hole_on [MAX_HOLES];
    t_out_item expected_results[$];

    function automatic void rebuild_table();
        for (int i = 0; i < MAX_HOLES; i++) begin
            hole_lo[i] = '0;
            hole_hi[i] = '0;
            hole_on[i] = 1'b0;
        end
        if (space_lo < space_hi) begin
            hole_lo[0] = space_lo;
            hole_hi[0] = space_hi;
            hole_on[0] = 1'b1;
        end
    endfunction

    function automatic int first_unused();
        for (int i = 0; i < MAX_HOLES; i++)
            if (!hole_on[i]) return i;
        return -1;
    endfunction

    function automatic t_out_item allocate_outcome(t_in_item it);
        t_out_item r;
        int h, lft, rgt, n;
        logic hit, keep_l, keep_r;
        r = '0;
        r.status = ST_NOFIT;
        h = -1;
        lft = -1;
        rgt = -1;
        hit = 1'b0;
        case (it.mode)
            MODE_FIND: begin
                for (int i = 0; i < MAX_HOLES; i++)
                    if (hole_on[i] && (hole_hi[i] - hole_lo[i]) >= it.want_length)
                        if (!hit || hole_lo[i] < r.found_addr) begin
                            r.found_addr = hole_lo[i];
                            hit = 1'b1;
                        end
                if (hit) r.status = ST_OK;
            end
            MODE_CONSUME: begin
                if (it.range_start < it.range_end) begin
                    for (int i = 0; i < MAX_HOLES && h < 0; i++)
                        if (hole_on[i] && hole_lo[i] <= it.range_start
                                && it.range_end <= hole_hi[i])
                            h = i;
                    if (h >= 0) begin
                        keep_l = it.range_start > hole_lo[h];
                        keep_r = hole_hi[h] > it.range_end;
                        r.status = ST_OK;
                        if (!keep_l && !keep_r) begin
                            hole_on[h] = 1'b0;
                            hole_lo[h] = '0;
                            hole_hi[h] = '0;
                        end else if (keep_l && !keep_r) begin
                            hole_hi[h] = it.range_start;
                        end else if (!keep_l) begin
                            hole_lo[h] = it.range_end;
                        end else begin
                            n = first_unused();
                            if (n < 0) begin
                                r.status = ST_FULL;
                            end else begin
                                hole_lo[n] = it.range_end;
                                hole_hi[n] = hole_hi[h];
                                hole_on[n] = 1'b1;
                                hole_hi[h] = it.range_start;
                            end
                        end
                    end
                end
            end
            MODE_RELEASE: begin
                if (it.range_start < it.range_end) begin
                    for (int i = 0; i < MAX_HOLES; i++) begin
                        if (hole_on[i] && lft < 0 && hole_hi[i] == it.range_start) lft = i;
                        if (hole_on[i] && rgt < 0 && hole_lo[i] == it.range_end) rgt = i;
                    end
                    r.status = ST_OK;
                    if (lft >= 0 && rgt >= 0 && lft != rgt) begin
                        hole_hi[lft] = hole_hi[rgt];
                        hole_on[rgt] = 1'b0;
                        hole_lo[rgt] = '0;
                        hole_hi[rgt] = '0;
                    end else if (lft >= 0) begin
                        hole_hi[lft] = it.range_end;
                    end else if (rgt >= 0) begin
                        hole_lo[rgt] = it.range_start;
                    end else begin
                        n = first_unused();
                        if (n < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            hole_lo[n] = it.range_start;
                            hole_hi[n] = it.range_end;
                            hole_on[n] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            space_lo = '0;
            space_hi = {ADDR_BITS{1'b1}};
            rebuild_table();
            expected_results.delete();
            o_errors = 0;
            o_results = 0;
            o_full_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%t: unexpected result status=%0d addr=%h", $realtime,
                                 i_out_item.status, i_out_item.found_addr);
                end else begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.status == ST_FULL) o_full_seen++;
                    if (i_out_item.status !== exp_item.status
                            || i_out_item.found_addr !== exp_item.found_addr) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%t: mismatch status exp %0d got %0d, addr exp %h got %h",
                                     $realtime, exp_item.status, i_out_item.status,
                                     exp_item.found_addr, i_out_item.found_addr);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(allocate_outcome(i_in_item));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RANGE_MIN) space_lo = i_cfg_data;
                else space_hi = i_cfg_data;
                rebuild_table();
            end
        end
        o_pending = expected_results.size();
    end
endmodule

// ===== dv/testbench.sv =====
// Testbench top: stimulus, reset, back-pressure and verdict for the allocator.
module testbench;
    import ffra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = MAX_HOLES + 4;
    localparam int QUIET_LIMIT = 20000;

    typedef logic [ADDR_BITS-1:0] t_addr;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    logic      cfg_we = 1'b0;
    logic      cfg_idx = 1'b0;
    t_addr     cfg_data = '0;
    int        errors, pending, results, full_seen;
    int        idle_pct = 34;
    bit        hold_off = 1'b0;
    int        quiet_cycles = 0;
    t_addr     base, span;

    always #6 clk = ~clk;

    first_fit_free_range_allocator i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    ffra_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_full_seen(full_seen)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired, pending=%0d", pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_addr rand_addr();
        return t_addr'({$urandom(), $urandom()});
    endfunction

    // valid drops only while idling, so back-to-back items keep it high
    task automatic send_item(logic [1:0] mode, t_addr s, t_addr e, t_addr len);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{mode: mode, range_start: s, range_end: e, want_length: len};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, t_addr val);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (3) @(negedge clk);
    endtask

    // well-formed traffic starting inside [base, base+span] mostly, with some noise
    task automatic random_op();
        t_addr s, e;
        int r;
        r = $urandom_range(99);
        s = base + t_addr'($urandom_range(32'(span)));
        e = s + t_addr'($urandom_range(32'(span / 8 + 1)));
        if (r < 30) send_item(MODE_FIND, rand_addr(), rand_addr(),
                              (r < 25) ? t_addr'($urandom_range(32'(span / 4))) : rand_addr());
        else if (r < 60) send_item(MODE_CONSUME, s, e, rand_addr());
        else if (r < 88) send_item(MODE_RELEASE, s, e, rand_addr());
        else if (r < 94) send_item(r[1:0], rand_addr(), rand_addr(), rand_addr());
        else send_item(2'd3, rand_addr(), rand_addr(), rand_addr());
    endtask

    initial begin
        t_addr ones;
        ones = '1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // directed: default space
        send_item(MODE_FIND, '0, '0, '0);
        send_item(MODE_FIND, ones, ones, ones);
        send_item(MODE_FIND, '0, '0, ones - 1);
        send_item(MODE_CONSUME, 10, 10, '0);
        send_item(MODE_RELEASE, 20, 5, '0);
        send_item(2'd3, ones, ones, ones);
        send_item(MODE_CONSUME, 100, 200, '0);
        send_item(MODE_CONSUME, '0, 100, '0);
        send_item(MODE_CONSUME, ones - 10, ones - 1, '0);
        send_item(MODE_FIND, '0, '0, 50);
        send_item(MODE_RELEASE, 100, 200, '0);
        send_item(MODE_RELEASE, '0, 100, '0);
        send_item(MODE_CONSUME, ones - 5, ones, '0);
        send_item(MODE_FIND, '0, '0, 5);
        // fill the table with splits, then more splits, a merging release and a lone release
        for (int i = 0; i < MAX_HOLES + 1; i++)
            send_item(MODE_CONSUME, 1000 + 4 * i, 1002 + 4 * i, '0);
        send_item(MODE_RELEASE, 1001, 1002, '0);
        send_item(MODE_RELEASE, 1002, 1004, '0);
        send_item(MODE_FIND, '0, '0, 3);

        // empty space, then the space from 500 up
        write_reg(CFG_RANGE_MIN, 500);
        write_reg(CFG_RANGE_MAX, 500);
        send_item(MODE_FIND, '0, '0, '0);
        send_item(MODE_RELEASE, 500, 510, '0);
        write_reg(CFG_RANGE_MAX, ones);
        send_item(MODE_FIND, '0, '0, '0);

        // back-pressure: receiver holds off while items keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_item(MODE_FIND, '0, '0, i);
        join

        for (int ph = 0; ph < 5; ph++) begin
            base = (ph == 4) ? ones - 4096 : t_addr'($urandom_range(1 << 20));
            span = (ph % 2) ? 4095 : 255;
            if (ph == 4) base = ones - span - 1;
            write_reg(CFG_RANGE_MIN, base);
            write_reg(CFG_RANGE_MAX, base + span);
            idle_pct = (ph == 2) ? 0 : 34;
            for (int i = 0; i < 110; i++) random_op();
        end
        idle_pct = 34;
        drain();

        $display("ran %0d results over directed corner cases and five random address spaces,",
                 results);
        $display("including %0d table-full outcomes and a long output hold-off", full_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
